/* hdl/svamp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svamp_pkg: shared types and constants of the servo angle ramp pulse mapper
// Command codes, register indexes, reset values, channel words and the
// control and status groups between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package svamp_pkg;

  // Command codes carried in the func field.
  localparam logic [2:0] FN_INIT      = 3'd0;
  localparam logic [2:0] FN_TICK      = 3'd1;
  localparam logic [2:0] FN_ENABLE    = 3'd2;
  localparam logic [2:0] FN_DISABLE   = 3'd3;
  localparam logic [2:0] FN_SET_ANGLE = 3'd4;
  localparam logic [2:0] FN_SET_PULSE = 3'd5;
  localparam logic [2:0] FN_SMOOTH    = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PULSE_LOW  = 3'd0;
  localparam logic [2:0] CFG_PULSE_HIGH = 3'd1;
  localparam logic [2:0] CFG_ANGLE_LOW  = 3'd2;
  localparam logic [2:0] CFG_ANGLE_HIGH = 3'd3;
  localparam logic [2:0] CFG_PERIOD     = 3'd4;

  // Default limits, also the fallbacks for invalid ranges.
  localparam int unsigned DefPulseLow  = 1000;
  localparam int unsigned DefPulseHigh = 2000;
  localparam int unsigned DefAngleLow  = 0;
  localparam int unsigned DefAngleHigh = 180;
  localparam int unsigned DefPeriod    = 20000;
  localparam int unsigned DefInterval  = 20;

  localparam logic [15:0] DEF_PULSE_LOW  = 16'(DefPulseLow);
  localparam logic [15:0] DEF_PULSE_HIGH = 16'(DefPulseHigh);
  localparam logic [15:0] DEF_ANGLE_LOW  = 16'(DefAngleLow);
  localparam logic [15:0] DEF_ANGLE_HIGH = 16'(DefAngleHigh);
  localparam logic [19:0] DEF_PERIOD     = 20'(DefPeriod);
  localparam logic [31:0] DEF_INTERVAL   = 32'(DefInterval);
  localparam logic [15:0] DEF_STEP       = 16'd1;

  // Angle and pulse right after reset: midpoint of the default range.
  localparam int unsigned RstAngle = (DefAngleLow + DefAngleHigh) / 2;
  localparam int unsigned RstPulse = DefPulseLow +
      ((RstAngle - DefAngleLow) * (DefPulseHigh - DefPulseLow)) /
      (DefAngleHigh - DefAngleLow);
  localparam logic [15:0] RST_ANGLE = 16'(RstAngle);
  localparam logic [15:0] RST_PULSE = 16'(RstPulse);

  // Restoring divider: one quotient bit per cycle over a 32-bit dividend.
  localparam int unsigned DivSteps = 32;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] angle_in;
    logic [15:0] pulse_in_us;
    logic [15:0] ramp_step;
    logic [31:0] ramp_interval_ms;
    logic [31:0] time_ms;
  } cmd_t;

  typedef struct packed {
    logic [15:0] angle_now;
    logic [15:0] pulse_now_us;
    logic [15:0] angle_goal;
    logic        is_moving;
    logic        is_enabled;
    logic        drive_update;
    logic        drive_on;
    logic        drive_off;
    logic [19:0] frame_period_out_us;
  } res_t;

  typedef struct packed {
    logic [2:0]  idx;
    logic [19:0] value;
  } cfg_t;

  // Sequencer to datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic mul;
    logic div_step;
    logic wb;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic need_map;
    logic out_free;
  } ctrl_stat_t;

endpackage
`default_nettype wire

/* hdl/svamp_chan_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svamp_chan_if: valid/ready channel
// Carries one word of type T from a source to a sink.
// ----------------------------------------------------------------------------
interface svamp_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/servo_angle_ramp_pulse_mapper.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// servo_angle_ramp_pulse_mapper: servo command generator
// Takes servo commands, keeps angle, pulse and ramp state and returns one
// status word per command with drive events.
// ----------------------------------------------------------------------------
//   channel  direction  word   content
//   cmd      in         cmd_t  func, angle, pulse, ramp step/interval, time
//   res      out        res_t  angle, pulse, goal, flags, events, period
//   cfg      in         cfg_t  register index and value, always ready
//
// A command that maps angle to pulse or back (init, set angle, set pulse,
// a tick that steps) goes through execute, multiply, the divide steps
// and write-back; the restoring divider yields one quotient bit per cycle.
// Other commands go from execute to output. A waiting result does not
// block the next command until that command's own result is ready. Reset
// is synchronous and restores the default limits and the midpoint angle.
// ----------------------------------------------------------------------------
module servo_angle_ramp_pulse_mapper
  import svamp_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  svamp_chan_if.sink   cmd,
  svamp_chan_if.source res,
  svamp_chan_if.sink   cfg
);

  ctrl_cmd_t  ctl;
  ctrl_stat_t stat;

  assign cfg.ready = 1'b1;

  svamp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  svamp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd_data  (cmd.data),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .res_ready (res.ready),
    .res_valid (res.valid),
    .res_data  (res.data),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule
`default_nettype wire

/* hdl/svamp_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svamp_ctrl: command sequencer
// Steps one command through execute and, for a mapping command, multiply,
// divide and write-back, and hands the finished word to the output register.
// ----------------------------------------------------------------------------
module svamp_ctrl
  import svamp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_ready,
  input  wire ctrl_stat_t stat,
  output ctrl_cmd_t       ctl
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_WB   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t             state, state_next;
  logic [DivCntW-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctl        = '0;
    cmd_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = stat.need_map ? S_MUL : S_OUT;
      end
      S_MUL: begin
        ctl.mul    = 1'b1;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DivCntW'(DivSteps - 1)) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        ctl.wb     = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/svamp_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svamp_datapath: servo state, limits and angle/pulse mapping
// Holds the registers, the servo state and the output word; maps between
// angle and pulse with one multiplier and a restoring divider.
// ----------------------------------------------------------------------------
module svamp_datapath
  import svamp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cmd_t      cmd_data,
  input  wire logic      cfg_valid,
  input  wire cfg_t      cfg_data,
  input  wire logic      res_ready,
  output logic           res_valid,
  output res_t           res_data,
  input  wire ctrl_cmd_t ctl,
  output ctrl_stat_t     stat
);

  // Configuration registers.
  logic [15:0] reg_plo, reg_phi, reg_alo, reg_ahi;
  logic [19:0] reg_period;

  // Effective limits latched at init.
  logic [15:0] plo, phi, alo, ahi;
  logic [19:0] period;

  // Servo state.
  logic [15:0] cur, goal, pulse, step;
  logic [31:0] intv, last;
  logic        en, ramp, mov;
  logic        upd, on, off;

  // Captured command and mapping datapath.
  cmd_t        c;
  logic        map_pulse;
  logic [47:0] rq;
  logic [15:0] den, base;

  // Fallback limits from the registers, used by init.
  logic [15:0] plo_n, phi_n, alo_n, ahi_n;
  logic [19:0] period_n;
  logic [16:0] mid_sum;

  always_comb begin
    if (reg_plo >= reg_phi) begin
      plo_n = DEF_PULSE_LOW;
      phi_n = DEF_PULSE_HIGH;
    end else begin
      plo_n = reg_plo;
      phi_n = reg_phi;
    end
    if (reg_alo >= reg_ahi) begin
      alo_n = DEF_ANGLE_LOW;
      ahi_n = DEF_ANGLE_HIGH;
    end else begin
      alo_n = reg_alo;
      ahi_n = reg_ahi;
    end
    period_n = (reg_period == '0) ? DEF_PERIOD : reg_period;
    mid_sum  = {1'b0, alo_n} + {1'b0, ahi_n};
  end

  // Clamps of the requested angle and pulse.
  logic [15:0] ang_clamp, pls_clamp;

  always_comb begin
    if (c.angle_in < alo) begin
      ang_clamp = alo;
    end else if (c.angle_in > ahi) begin
      ang_clamp = ahi;
    end else begin
      ang_clamp = c.angle_in;
    end
    if (c.pulse_in_us < plo) begin
      pls_clamp = plo;
    end else if (c.pulse_in_us > phi) begin
      pls_clamp = phi;
    end else begin
      pls_clamp = c.pulse_in_us;
    end
  end

  // Ramp step: the upward sum keeps its carry so a wrap stops at the goal.
  logic [31:0] elapsed;
  logic        tick_go;
  logic [16:0] up_sum;
  logic [15:0] dn_val, nxt;

  always_comb begin
    elapsed = c.time_ms - last;
    tick_go = en && ramp && mov && (elapsed >= intv);
    up_sum  = {1'b0, cur} + {1'b0, step};
    dn_val  = (cur > step) ? cur - step : 16'd0;
    if (cur < goal) begin
      nxt = (up_sum > {1'b0, goal}) ? goal : up_sum[15:0];
    end else begin
      nxt = (dn_val < goal) ? goal : dn_val;
    end
  end

  // Drive events and mapping direction of the command in execute.
  logic upd_next, on_next, off_next, map_pulse_next;

  always_comb begin
    upd_next       = 1'b0;
    on_next        = 1'b0;
    off_next       = 1'b0;
    map_pulse_next = 1'b1;
    case (c.func)
      FN_TICK: begin
        upd_next = tick_go;
      end
      FN_ENABLE: begin
        on_next  = 1'b1;
        upd_next = 1'b1;
      end
      FN_DISABLE: begin
        off_next = 1'b1;
      end
      FN_SET_ANGLE: begin
        upd_next = en;
      end
      FN_SET_PULSE: begin
        upd_next       = en;
        map_pulse_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.out_free = !res_valid || res_ready;
    case (c.func)
      FN_INIT, FN_SET_ANGLE, FN_SET_PULSE: stat.need_map = 1'b1;
      FN_TICK:                             stat.need_map = tick_go;
      default:                             stat.need_map = 1'b0;
    endcase
  end

  // Mapping operands come from the state as it stands after execute.
  logic [15:0] mul_a, mul_b;
  logic [16:0] trial, diff;
  logic        qbit;
  logic [15:0] map_res;

  always_comb begin
    mul_a   = map_pulse ? cur - alo : pulse - plo;
    mul_b   = map_pulse ? phi - plo : ahi - alo;
    trial   = {rq[47:32], rq[31]};
    diff    = trial - {1'b0, den};
    qbit    = (trial >= {1'b0, den});
    map_res = base + rq[15:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      c <= cmd_data;
    end
    if (ctl.mul) begin
      rq   <= {16'd0, 32'(mul_a) * 32'(mul_b)};
      den  <= map_pulse ? ahi - alo : phi - plo;
      base <= map_pulse ? plo : alo;
    end else if (ctl.div_step) begin
      rq <= {(qbit ? diff[15:0] : trial[15:0]), rq[30:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_plo    <= DEF_PULSE_LOW;
      reg_phi    <= DEF_PULSE_HIGH;
      reg_alo    <= DEF_ANGLE_LOW;
      reg_ahi    <= DEF_ANGLE_HIGH;
      reg_period <= DEF_PERIOD;
    end else if (cfg_valid) begin
      case (cfg_data.idx)
        CFG_PULSE_LOW:  reg_plo    <= cfg_data.value[15:0];
        CFG_PULSE_HIGH: reg_phi    <= cfg_data.value[15:0];
        CFG_ANGLE_LOW:  reg_alo    <= cfg_data.value[15:0];
        CFG_ANGLE_HIGH: reg_ahi    <= cfg_data.value[15:0];
        CFG_PERIOD:     reg_period <= cfg_data.value;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plo       <= DEF_PULSE_LOW;
      phi       <= DEF_PULSE_HIGH;
      alo       <= DEF_ANGLE_LOW;
      ahi       <= DEF_ANGLE_HIGH;
      period    <= DEF_PERIOD;
      cur       <= RST_ANGLE;
      goal      <= RST_ANGLE;
      pulse     <= RST_PULSE;
      step      <= DEF_STEP;
      intv      <= DEF_INTERVAL;
      last      <= '0;
      en        <= 1'b0;
      ramp      <= 1'b0;
      mov       <= 1'b0;
      upd       <= 1'b0;
      on        <= 1'b0;
      off       <= 1'b0;
      map_pulse <= 1'b1;
    end else if (ctl.exec) begin
      upd       <= upd_next;
      on        <= on_next;
      off       <= off_next;
      map_pulse <= map_pulse_next;
      case (c.func)
        FN_INIT: begin
          plo    <= plo_n;
          phi    <= phi_n;
          alo    <= alo_n;
          ahi    <= ahi_n;
          period <= period_n;
          cur    <= mid_sum[16:1];
          goal   <= mid_sum[16:1];
          step   <= DEF_STEP;
          intv   <= DEF_INTERVAL;
          last   <= '0;
          en     <= 1'b0;
          ramp   <= 1'b0;
          mov    <= 1'b0;
        end
        FN_TICK: begin
          if (tick_go) begin
            last <= c.time_ms;
            cur  <= nxt;
            if (nxt == goal) begin
              mov  <= 1'b0;
              ramp <= 1'b0;
            end
          end
        end
        FN_ENABLE: begin
          en <= 1'b1;
        end
        FN_DISABLE: begin
          en   <= 1'b0;
          ramp <= 1'b0;
          mov  <= 1'b0;
        end
        FN_SET_ANGLE: begin
          ramp <= 1'b0;
          mov  <= 1'b0;
          cur  <= ang_clamp;
          goal <= ang_clamp;
        end
        FN_SET_PULSE: begin
          ramp  <= 1'b0;
          mov   <= 1'b0;
          pulse <= pls_clamp;
        end
        FN_SMOOTH: begin
          goal <= ang_clamp;
          step <= (c.ramp_step == '0) ? DEF_STEP : c.ramp_step;
          intv <= (c.ramp_interval_ms == '0) ? 32'd1 : c.ramp_interval_ms;
          last <= c.time_ms;
          ramp <= 1'b1;
          mov  <= (cur != ang_clamp);
        end
        default: begin
        end
      endcase
    end else if (ctl.wb) begin
      if (map_pulse) begin
        pulse <= map_res;
      end else begin
        cur  <= map_res;
        goal <= map_res;
      end
    end
  end

  // Output register: the next command may run while this word waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      res_data.angle_now           <= cur;
      res_data.pulse_now_us        <= pulse;
      res_data.angle_goal          <= goal;
      res_data.is_moving           <= mov;
      res_data.is_enabled          <= en;
      res_data.drive_update        <= upd;
      res_data.drive_on            <= on;
      res_data.drive_off           <= off;
      res_data.frame_period_out_us <= period;
    end
  end

endmodule
`default_nettype wire

/* hdl/svamp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svamp_checker: port checks of the servo mapper
// Watches the command and result channels and the drive events.
// ----------------------------------------------------------------------------
module svamp_checker
  import svamp_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic cmd_valid,
  input wire logic cmd_ready,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire res_t res_data
);

  // A result word holds until it is taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
    else $error("result word dropped or changed while stalled");

  // One command at a time: after an accept the command side closes.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command accepted while another was in progress");

  // Switching on always applies a frame and leaves the drive enabled.
  a_on_upd: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.drive_on) |->
      (res_data.drive_update && res_data.is_enabled && !res_data.drive_off))
    else $error("drive on without update or enable");

  // Switching off stops any move and clears enable.
  a_off_stop: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.drive_off) |->
      (!res_data.is_enabled && !res_data.is_moving && !res_data.drive_update))
    else $error("drive off while still enabled or moving");

  // A reset leaves no result word pending.
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind servo_angle_ramp_pulse_mapper svamp_checker u_svamp_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: servo angle ramp pulse mapper
// Drives servo commands and limit register writes through valid/ready
// channels. A status model predicts the status word of each accepted command,
// and every returned word is compared field by field against the oldest one.
// The run covers a directed sweep, then random ramp sequences mixed with
// noise under several limit settings and idling patterns.
// ----------------------------------------------------------------------------
module testbench;
  import svamp_pkg::*;

  localparam int ClkPeriod     = 4;
  localparam int PhaseItems    = 140;
  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles    = 400;

  // Codes the block defines no behavior for, other than ignoring them.
  localparam logic [2:0] FN_UNUSED = 3'd7;
  localparam logic [2:0] CFG_SPARE = 3'd5;

  class servo_status_model;
    logic [15:0] reg_plo, reg_phi, reg_alo, reg_ahi;
    logic [19:0] reg_period;
    logic [15:0] lim_plo, lim_phi, lim_alo, lim_ahi;
    logic [19:0] lim_period;
    logic [15:0] angle, goal, pulse, step;
    logic [31:0] interval, last_ms;
    bit          enabled, ramping, moving;
    res_t        pending_status[$];
    int          errors;

    function new();
      reg_plo    = DEF_PULSE_LOW;
      reg_phi    = DEF_PULSE_HIGH;
      reg_alo    = DEF_ANGLE_LOW;
      reg_ahi    = DEF_ANGLE_HIGH;
      reg_period = DEF_PERIOD;
      errors     = 0;
      latch_limits();
    endfunction

    function logic [15:0] clamp16(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function logic [15:0] to_pulse(logic [15:0] a);
      int unsigned den, span, ofs;
      den  = lim_ahi - lim_alo;
      span = lim_phi - lim_plo;
      ofs  = clamp16(a, lim_alo, lim_ahi) - lim_alo;
      if (den == 0) return lim_plo;
      return 16'(lim_plo + (ofs * span) / den);
    endfunction

    // Latched limits with fallbacks; the rest of the state restarts too.
    function void latch_limits();
      int unsigned mid;
      lim_plo = reg_plo;
      lim_phi = reg_phi;
      if (lim_plo >= lim_phi) begin
        lim_plo = DEF_PULSE_LOW;
        lim_phi = DEF_PULSE_HIGH;
      end
      lim_alo = reg_alo;
      lim_ahi = reg_ahi;
      if (lim_alo >= lim_ahi) begin
        lim_alo = DEF_ANGLE_LOW;
        lim_ahi = DEF_ANGLE_HIGH;
      end
      lim_period = (reg_period == 0) ? DEF_PERIOD : reg_period;
      mid      = lim_alo + lim_ahi;
      angle    = 16'(mid / 2);
      goal     = angle;
      pulse    = to_pulse(angle);
      enabled  = 0;
      ramping  = 0;
      moving   = 0;
      step     = DEF_STEP;
      interval = DEF_INTERVAL;
      last_ms  = 0;
    endfunction

    function void write_reg(cfg_t w);
      case (w.idx)
        CFG_PULSE_LOW:  reg_plo = w.value[15:0];
        CFG_PULSE_HIGH: reg_phi = w.value[15:0];
        CFG_ANGLE_LOW:  reg_alo = w.value[15:0];
        CFG_ANGLE_HIGH: reg_ahi = w.value[15:0];
        CFG_PERIOD:     reg_period = w.value;
        default: ;
      endcase
    endfunction

    function void take_command(cmd_t c);
      res_t        e;
      logic [31:0] elapsed;
      int unsigned nxt, pden, aspan, pofs;
      bit          upd, on, off;
      upd = 0;
      on  = 0;
      off = 0;
      case (c.func)
        FN_INIT: latch_limits();
        FN_TICK: begin
          elapsed = c.time_ms - last_ms;
          if (enabled && ramping && moving && elapsed >= interval) begin
            last_ms = c.time_ms;
            if (angle < goal) begin
              nxt = angle + step;
              if (nxt > goal) nxt = goal;
            end else begin
              nxt = (angle > step) ? angle - step : 0;
              if (nxt < goal) nxt = goal;
            end
            angle = 16'(nxt);
            pulse = to_pulse(angle);
            upd   = 1;
            if (angle == goal) begin
              moving  = 0;
              ramping = 0;
            end
          end
        end
        FN_ENABLE: begin
          enabled = 1;
          on      = 1;
          upd     = 1;
        end
        FN_DISABLE: begin
          enabled = 0;
          ramping = 0;
          moving  = 0;
          off     = 1;
        end
        FN_SET_ANGLE: begin
          ramping = 0;
          moving  = 0;
          angle   = clamp16(c.angle_in, lim_alo, lim_ahi);
          goal    = angle;
          pulse   = to_pulse(angle);
          upd     = enabled;
        end
        FN_SET_PULSE: begin
          ramping = 0;
          moving  = 0;
          pulse   = clamp16(c.pulse_in_us, lim_plo, lim_phi);
          pden    = lim_phi - lim_plo;
          aspan   = lim_ahi - lim_alo;
          pofs    = pulse - lim_plo;
          angle   = (pden == 0) ? lim_alo : 16'(lim_alo + (pofs * aspan) / pden);
          goal    = angle;
          upd     = enabled;
        end
        FN_SMOOTH: begin
          goal     = clamp16(c.angle_in, lim_alo, lim_ahi);
          step     = (c.ramp_step == 0) ? 16'd1 : c.ramp_step;
          interval = (c.ramp_interval_ms == 0) ? 32'd1 : c.ramp_interval_ms;
          last_ms  = c.time_ms;
          ramping  = 1;
          moving   = (angle != goal);
        end
        default: ;
      endcase
      e.angle_now           = angle;
      e.pulse_now_us        = pulse;
      e.angle_goal          = goal;
      e.is_moving           = moving;
      e.is_enabled          = enabled;
      e.drive_update        = upd;
      e.drive_on            = on;
      e.drive_off           = off;
      e.frame_period_out_us = lim_period;
      pending_status.push_back(e);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_status(res_t r);
      res_t want;
      if (pending_status.size() == 0) begin
        $error("status word returned with no command waiting");
        errors++;
        return;
      end
      want = pending_status.pop_front();
      cmp("angle_now", 32'(want.angle_now), 32'(r.angle_now));
      cmp("pulse_now_us", 32'(want.pulse_now_us), 32'(r.pulse_now_us));
      cmp("angle_goal", 32'(want.angle_goal), 32'(r.angle_goal));
      cmp("is_moving", 32'(want.is_moving), 32'(r.is_moving));
      cmp("is_enabled", 32'(want.is_enabled), 32'(r.is_enabled));
      cmp("drive_update", 32'(want.drive_update), 32'(r.drive_update));
      cmp("drive_on", 32'(want.drive_on), 32'(r.drive_on));
      cmp("drive_off", 32'(want.drive_off), 32'(r.drive_off));
      cmp("frame_period_out_us", 32'(want.frame_period_out_us),
          32'(r.frame_period_out_us));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  svamp_chan_if #(.T(cmd_t)) cmd_ch ();
  svamp_chan_if #(.T(res_t)) res_ch ();
  svamp_chan_if #(.T(cfg_t)) cfg_ch ();

  servo_angle_ramp_pulse_mapper dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  servo_status_model status_model;
  int          stall_pct;
  int          gap_pct;
  bit          hold_req;
  int          hold_left = 0;
  int          idle_cycles = 0;
  int          sent_items = 0;
  logic [31:0] now_ms;

  always #(ClkPeriod / 2) clk = ~clk;

  // Result side: random stalls, plus one long hold-off when asked for.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        status_model.check_status(res_ch.data);
        moved = 1'b1;
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        status_model.take_command(cmd_ch.data);
        moved = 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        status_model.write_reg(cfg_ch.data);
        moved = 1'b1;
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("servo_angle_ramp_pulse_mapper test failed");
      $finish;
    end
  end

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.func             = 3'($urandom_range(0, 7));
    c.angle_in         = 16'($urandom);
    c.pulse_in_us      = 16'($urandom);
    c.ramp_step        = 16'($urandom);
    c.ramp_interval_ms = $urandom;
    c.time_ms          = $urandom;
    return c;
  endfunction

  function automatic cmd_t mk(logic [2:0] f, logic [15:0] a, logic [15:0] p,
                              logic [15:0] s, logic [31:0] iv, logic [31:0] tm);
    cmd_t c;
    c.func             = f;
    c.angle_in         = a;
    c.pulse_in_us      = p;
    c.ramp_step        = s;
    c.ramp_interval_ms = iv;
    c.time_ms          = tm;
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the accept
  // with valid still high, so back-to-back words keep valid high between them.
  task automatic send_cmd(input cmd_t c);
    while ($urandom_range(0, 99) < gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.data  <= c;
    cmd_ch.valid <= 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [19:0] value);
    cfg_ch.data  <= '{idx: idx, value: value};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic program_limits(input logic [15:0] plo, input logic [15:0] phi,
                                input logic [15:0] alo, input logic [15:0] ahi,
                                input logic [19:0] per);
    put_reg(CFG_SPARE, 20'($urandom));
    put_reg(CFG_PULSE_LOW, {4'($urandom), plo});
    put_reg(CFG_PULSE_HIGH, {4'($urandom), phi});
    put_reg(CFG_ANGLE_LOW, {4'($urandom), alo});
    put_reg(CFG_ANGLE_HIGH, {4'($urandom), ahi});
    put_reg(CFG_PERIOD, per);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    cmd_ch.valid <= 1'b0;
    while (status_model.pending_status.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Mostly enable, then start a move, then a run of ticks with time creeping forward.
  // Now and then a tick is replaced by some other command or time jumps.
  task automatic run_ramp();
    cmd_t c;
    int   ticks;
    if ($urandom_range(0, 9) < 8) begin
      c = rand_cmd();
      c.func = FN_ENABLE;
      send_cmd(c);
    end
    c = rand_cmd();
    c.func = FN_SMOOTH;
    if ($urandom_range(0, 9) < 7)
      c.angle_in = 16'($urandom_range(status_model.lim_ahi, status_model.lim_alo));
    case ($urandom_range(0, 3))
      0: c.ramp_step = 16'd0;
      1: c.ramp_step = 16'($urandom_range(1, 8));
      2: c.ramp_step = 16'($urandom_range(1, 64));
      default: ;
    endcase
    if ($urandom_range(0, 7) != 0) c.ramp_interval_ms = $urandom_range(0, 4);
    c.time_ms = now_ms;
    send_cmd(c);
    ticks = $urandom_range(1, 12);
    repeat (ticks) begin
      if ($urandom_range(0, 15) == 0) now_ms = $urandom;
      else now_ms += $urandom_range(0, 6);
      c = rand_cmd();
      c.func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7)) : FN_TICK;
      c.time_ms = now_ms;
      send_cmd(c);
    end
  endtask

  initial begin
    int   stop_at;
    cmd_t c;
    status_model = new();
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    res_ch.ready = 1'b0;
    stall_pct    = 0;
    gap_pct      = 0;
    hold_req     = 1'b0;
    now_ms       = 32'd0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed sweep at the reset limits.
    send_cmd(mk(FN_TICK, 16'd0, 16'd0, 16'd0, 32'd0, 32'd100));
    send_cmd(mk(FN_SET_ANGLE, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0));
    send_cmd(mk(FN_SET_ANGLE, 16'hFFFF, 16'd0, 16'd0, 32'd0, 32'd0));
    send_cmd(mk(FN_SET_PULSE, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0));
    send_cmd(mk(FN_SET_PULSE, 16'd0, 16'hFFFF, 16'd0, 32'd0, 32'd0));
    send_cmd(mk(FN_ENABLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_cmd(mk(FN_SET_ANGLE, 16'd90, 16'd0, 16'd0, 32'd0, 32'd0));
    send_cmd(mk(FN_SMOOTH, 16'd100, 16'd0, 16'd0, 32'd0, 32'd1000));
    send_cmd(mk(FN_TICK, 16'd0, 16'd0, 16'd0, 32'd0, 32'd1000));
    send_cmd(mk(FN_TICK, 16'd0, 16'd0, 16'd0, 32'd0, 32'd1001));
    send_cmd(mk(FN_SMOOTH, 16'd0, 16'd0, 16'hFFFF, 32'd5, 32'd1002));
    send_cmd(mk(FN_TICK, 16'd0, 16'd0, 16'd0, 32'd0, 32'd1006));
    send_cmd(mk(FN_TICK, 16'd0, 16'd0, 16'd0, 32'd0, 32'd1007));
    send_cmd(mk(FN_SMOOTH, 16'hFFFF, 16'd0, 16'hFFFF, 32'd1, 32'd1008));
    send_cmd(mk(FN_TICK, 16'd0, 16'd0, 16'd0, 32'd0, 32'd1009));
    send_cmd(mk(FN_SMOOTH, 16'd180, 16'd0, 16'd3, 32'd1, 32'd1010));
    send_cmd(mk(FN_TICK, 16'd0, 16'd0, 16'd0, 32'd0, 32'd1020));
    send_cmd(mk(FN_SMOOTH, 16'd0, 16'd0, 16'd1, 32'd10, 32'hFFFF_FFFA));
    send_cmd(mk(FN_TICK, 16'd0, 16'd0, 16'd0, 32'd0, 32'h0000_0004));
    send_cmd(mk(FN_SMOOTH, 16'd0, 16'd0, 16'd1, 32'hFFFF_FFFF, 32'd0));
    send_cmd(mk(FN_TICK, 16'd0, 16'd0, 16'd0, 32'd0, 32'hFFFF_FFFE));
    send_cmd(mk(FN_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_cmd(mk(FN_DISABLE, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0));
    send_cmd(mk(FN_TICK, 16'd0, 16'd0, 16'd0, 32'd0, 32'd5000));
    send_cmd(mk(FN_INIT, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0));
    wait_drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin stall_pct = 0;  gap_pct = 0;  end
        1: begin stall_pct = 0;  gap_pct = 51; end
        2: begin stall_pct = 51; gap_pct = 0;  end
        default: begin stall_pct = 19; gap_pct = 19; end
      endcase
      case (p)
        0: program_limits(16'd1000, 16'd2000, 16'd0, 16'd180, 20'd20000);
        1: program_limits(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 20'hFFFFF);
        2: program_limits(16'd1500, 16'd1500, 16'd200, 16'd100, 20'd0);
        3: program_limits(16'd1500, 16'd1501, 16'd10, 16'd11, 20'd1);
        4: program_limits(16'd3000, 16'd1000, 16'd30, 16'd150, 20'd1000000);
        default: program_limits(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 20'($urandom));
      endcase
      c = rand_cmd();
      c.func = FN_INIT;
      send_cmd(c);
      now_ms = (p % 2 == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 200)
                            : $urandom_range(0, 1000);
      // The sender keeps offering words while the result side holds off.
      if (p == 1) hold_req = 1'b1;
      stop_at = sent_items + PhaseItems;
      while (sent_items < stop_at) begin
        if ($urandom_range(0, 99) < 70) run_ramp();
        else repeat ($urandom_range(1, 3)) send_cmd(rand_cmd());
      end
      wait_drain();
    end

    repeat (40) @(negedge clk);
    if (status_model.errors == 0 && status_model.pending_status.size() == 0) begin
      $display("servo_angle_ramp_pulse_mapper test passed");
    end else begin
      $display("servo_angle_ramp_pulse_mapper test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/svamp_pkg.sv
hdl/svamp_chan_if.sv
hdl/svamp_ctrl.sv
hdl/svamp_datapath.sv
hdl/servo_angle_ramp_pulse_mapper.sv
hdl/svamp_checker.sv
tb/testbench.sv
